// ===== rtl/core/ems_pkg.sv =====
// ----------------------------------------------------------------------------
// ems_pkg: shared types and constants of the span filler
// Command codes, field widths and the command word passed from the front
// end to the back end.
// ----------------------------------------------------------------------------
package ems_pkg;

	localparam int COL_W = 6;
	localparam int ROW_W = 10;
	localparam int MAP_AW = 14;
	localparam int ACC_W = 40;
	localparam logic [31:0] DEPTH_FILL = 32'h5555_5555;
	localparam logic [15:0] SLACK_RESET = 16'd500;
	localparam logic [MAP_AW-1:0] MAP_BIAS = 14'd64;
	localparam logic [6:0] MAP_ROW_BIAS = 7'd64;

	// register byte addresses
	localparam logic [1:0] CFG_DEPTH_SLACK = 2'd0;

	// input function codes
	localparam logic [1:0] FUNC_DRAW = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_LOAD = 2'd2;

	typedef enum logic [1:0] {
		CMD_SPAN  = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_LOAD  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [COL_W-1:0]   x_first;
		logic [COL_W-1:0]   x_last;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   len;
		logic signed [31:0] depth0;
		logic signed [31:0] nx0;
		logic signed [31:0] ny0;
		logic signed [32:0] depth_span;
		logic signed [32:0] nx_span;
		logic signed [32:0] ny_span;
		logic [MAP_AW-1:0]  map_address;
		logic [7:0]         map_byte;
	} span_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ===== rtl/core/ems_queue.sv =====
// ----------------------------------------------------------------------------
// ems_queue: two-entry command queue
// Decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ems_queue
	import ems_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  span_cmd_t push_cmd,
	output logic      full,
	input  logic      pop,
	output logic      avail,
	output span_cmd_t head
);

	span_cmd_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign avail = (count_q != 2'd0);
	assign head = slot_q[rd_ptr_q];

	// track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	// store payload
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ===== rtl/core/ems_front.sv =====
// ----------------------------------------------------------------------------
// ems_front: item classifier
// Rejects off-screen and empty spans, clips x, and forms the command word.
// ----------------------------------------------------------------------------
module ems_front
	import ems_pkg::*;
#(
	parameter int SCREEN_WIDTH = 64,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic               item_valid,
	input  logic               queue_full,
	output logic               item_stall,
	input  logic [1:0]         func,
	input  logic signed [15:0] x_start,
	input  logic signed [15:0] x_end,
	input  logic signed [15:0] row,
	input  logic signed [31:0] depth_start,
	input  logic signed [31:0] depth_end,
	input  logic signed [31:0] normal_x_start,
	input  logic signed [31:0] normal_y_start,
	input  logic signed [31:0] normal_x_end,
	input  logic signed [31:0] normal_y_end,
	input  logic [MAP_AW-1:0]  map_address,
	input  logic [7:0]         map_byte,
	output logic               push,
	output span_cmd_t          push_cmd
);

	localparam logic signed [16:0] W_S = 17'(SCREEN_WIDTH);
	localparam logic signed [16:0] H_S = 17'(SCREEN_HEIGHT);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(SCREEN_WIDTH - 1);

	logic signed [16:0] x1_e, x2_e, row_e;
	logic               on_screen;
	logic [COL_W-1:0]   x1_c, x2_c;
	logic [COL_W:0]     len_c;
	logic               keep;

	assign item_stall = queue_full;

	// clip and classify
	always_comb begin
		x1_e = 17'(x_start);
		x2_e = 17'(x_end);
		row_e = 17'(row);
		on_screen = (row_e < H_S) && (row_e >= 17'sd0) && (x2_e >= 17'sd0) && (x1_e < W_S);
		x1_c = (x1_e < 17'sd0) ? '0 : x1_e[COL_W-1:0];
		x2_c = (x2_e >= W_S) ? COL_LAST : x2_e[COL_W-1:0];
		len_c = {1'b0, x2_c} - {1'b0, x1_c};
		keep = 1'b0;
		push_cmd.kind = CMD_SPAN;
		unique case (func)
			FUNC_DRAW: begin
				keep = on_screen && !len_c[COL_W] && (len_c != '0);
			end
			FUNC_CLEAR: begin
				keep = 1'b1;
				push_cmd.kind = CMD_CLEAR;
			end
			FUNC_LOAD: begin
				keep = 1'b1;
				push_cmd.kind = CMD_LOAD;
			end
			default: keep = 1'b0;
		endcase
		push_cmd.x_first = x1_c;
		push_cmd.x_last = x2_c;
		push_cmd.row = row_e[ROW_W-1:0];
		push_cmd.len = len_c[COL_W-1:0];
		push_cmd.depth0 = depth_start;
		push_cmd.nx0 = normal_x_start;
		push_cmd.ny0 = normal_y_start;
		push_cmd.depth_span = 33'(depth_end) - 33'(depth_start);
		push_cmd.nx_span = 33'(normal_x_end) - 33'(normal_x_start);
		push_cmd.ny_span = 33'(normal_y_end) - 33'(normal_y_start);
		push_cmd.map_address = map_address;
		push_cmd.map_byte = map_byte;
	end

	assign push = item_valid && !queue_full && keep;

endmodule

// ===== rtl/core/ems_div.sv =====
// ----------------------------------------------------------------------------
// ems_div: three-lane step divider
// Truncating signed division of three 33-bit spans by the span length,
// one quotient bit per cycle, restoring.
// ----------------------------------------------------------------------------
module ems_div
	import ems_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [COL_W-1:0]   divisor,
	input  logic signed [32:0] num [3],
	output logic signed [32:0] quot [3],
	output div_status_t        status
);

	logic [32:0]      mag_q [3];
	logic [COL_W-1:0] rem_q [3];
	logic             neg_q [3];
	logic [COL_W-1:0] div_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [COL_W:0]   trial [3];
	logic             qbit [3];
	logic [COL_W:0]   diff [3];

	// one restoring step per lane
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			trial[i] = {rem_q[i], mag_q[i][32]};
			diff[i] = trial[i] - {1'b0, div_q};
			qbit[i] = (trial[i] >= {1'b0, div_q});
		end
	end

	// sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd33;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift dividend out and quotient in
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			for (int i = 0; i < 3; i++) begin
				neg_q[i] <= num[i][32];
				mag_q[i] <= num[i][32] ? 33'(-num[i]) : num[i];
				rem_q[i] <= '0;
			end
		end else if (busy_q) begin
			for (int i = 0; i < 3; i++) begin
				mag_q[i] <= {mag_q[i][31:0], qbit[i]};
				rem_q[i] <= qbit[i] ? diff[i][COL_W-1:0] : trial[i][COL_W-1:0];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			quot[i] = neg_q[i] ? -$signed(mag_q[i]) : $signed(mag_q[i]);
	end

	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

// ===== rtl/core/ems_back.sv =====
// ----------------------------------------------------------------------------
// ems_back: span execution
// Clears the depth store, loads the map, and walks a span one pixel at a
// time with a depth read-modify-write: a read state, then a test-and-write state.
// ----------------------------------------------------------------------------
module ems_back
	import ems_pkg::*;
#(
	parameter int SCREEN_WIDTH = 64,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_avail,
	input  span_cmd_t         cmd,
	output logic              cmd_pop,
	input  logic [15:0]       depth_slack,
	output logic              pix_valid,
	input  logic              pix_stall,
	output logic [COL_W-1:0]  pixel_column,
	output logic [5:0]        pixel_row,
	output logic [7:0]        pixel_color,
	output logic              last
);

	localparam int DEPTH_WORDS = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int DA_W = (DEPTH_WORDS > 1) ? $clog2(DEPTH_WORDS) : 1;
	localparam logic [DA_W-1:0] DEPTH_LAST = DA_W'(DEPTH_WORDS - 1);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_DIV   = 6'b000100,
		S_RD    = 6'b001000,
		S_EV    = 6'b010000,
		S_FLUSH = 6'b100000
	} state_t;

	state_t                   state_q;
	logic [DA_W-1:0]          clr_q;
	logic [COL_W-1:0]         x_q, xl_q;
	logic [ROW_W-1:0]         row_q;
	logic signed [ACC_W-1:0]  nx_q, ny_q, nz_q;
	logic [31:0]              depth_mem [DEPTH_WORDS];
	logic [7:0]               map_mem [2**MAP_AW];
	logic [31:0]              stored_q;
	logic [7:0]               texel_q;
	logic                     pend_q;
	logic [COL_W-1:0]         pend_col_q;
	logic [7:0]               pend_color_q;
	logic                     out_valid_q;
	logic [COL_W-1:0]         out_col_q;
	logic [5:0]               out_row_q;
	logic [7:0]               out_color_q;
	logic                     out_last_q;

	logic signed [32:0]       div_num [3];
	logic signed [32:0]       div_q [3];
	div_status_t              div_st;
	logic                     div_start;
	logic [DA_W-1:0]          daddr;
	logic [ACC_W-1:0]         anx, any;
	logic [MAP_AW-1:0]        maddr;
	logic signed [31:0]       d_new;
	logic signed [33:0]       d_diff;
	logic                     pass;
	logic                     out_busy;
	logic                     ev_go;
	logic                     depth_we;
	logic                     map_we;

	assign div_num[0] = cmd.depth_span;
	assign div_num[1] = cmd.nx_span;
	assign div_num[2] = cmd.ny_span;
	assign div_start = (state_q == S_IDLE) && cmd_avail && (cmd.kind == CMD_SPAN);
	assign cmd_pop = (state_q == S_IDLE) && cmd_avail;

	ems_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (cmd.len),
		.num     (div_num),
		.quot    (div_q),
		.status  (div_st)
	);

	// pixel address, texel address and depth test
	always_comb begin
		daddr = DA_W'(32'(row_q) * 32'(SCREEN_WIDTH) + 32'(x_q));
		anx = nx_q[ACC_W-1] ? ACC_W'(-nx_q) : ACC_W'(nx_q);
		any = ny_q[ACC_W-1] ? ACC_W'(-ny_q) : ACC_W'(ny_q);
		maddr = {any[13:7] + MAP_ROW_BIAS, 7'd0} + (anx[20:7] + MAP_BIAS);
		d_new = nz_q[39:8];
		d_diff = 34'(d_new) - 34'($signed(stored_q));
		pass = d_diff < $signed({18'd0, depth_slack});
		out_busy = out_valid_q && pix_stall;
		ev_go = !(pass && pend_q && out_busy);
	end

	assign depth_we = ((state_q == S_EV) && ev_go && pass) || (state_q == S_CLEAR);
	assign map_we = (state_q == S_IDLE) && cmd_avail && (cmd.kind == CMD_LOAD);

	// depth store: one write port, registered read
	always_ff @(posedge clk) begin
		if (depth_we)
			depth_mem[(state_q == S_CLEAR) ? clr_q : daddr] <=
				(state_q == S_CLEAR) ? DEPTH_FILL : d_new;
		if (state_q == S_RD)
			stored_q <= depth_mem[daddr];
	end

	// environment map: load writes, pixel reads
	always_ff @(posedge clk) begin
		if (map_we)
			map_mem[cmd.map_address] <= cmd.map_byte;
		if (state_q == S_RD)
			texel_q <= map_mem[maddr];
	end

	// sequence commands and pixels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !pix_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == DEPTH_LAST)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cmd_avail) begin
						if (cmd.kind == CMD_CLEAR) begin
							clr_q <= '0;
							state_q <= S_CLEAR;
						end else if (cmd.kind == CMD_SPAN)
							state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_st.done)
						state_q <= S_RD;
				end
				S_RD: state_q <= S_EV;
				S_EV: begin
					if (ev_go) begin
						if (pass) begin
							pend_q <= 1'b1;
							if (pend_q)
								out_valid_q <= 1'b1;
						end
						state_q <= (x_q == xl_q) ? S_FLUSH : S_RD;
					end
				end
				S_FLUSH: begin
					if (!pend_q)
						state_q <= S_IDLE;
					else if (!out_busy) begin
						out_valid_q <= 1'b1;
						pend_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// span walkers and pixel payload
	always_ff @(posedge clk) begin
		if (div_start) begin
			x_q <= cmd.x_first;
			xl_q <= cmd.x_last;
			row_q <= cmd.row;
			nz_q <= ACC_W'(cmd.depth0);
			nx_q <= ACC_W'(cmd.nx0);
			ny_q <= ACC_W'(cmd.ny0);
		end
		if ((state_q == S_EV) && ev_go) begin
			x_q <= x_q + 1'b1;
			nz_q <= nz_q + ACC_W'(div_q[0]);
			nx_q <= nx_q + ACC_W'(div_q[1]);
			ny_q <= ny_q + ACC_W'(div_q[2]);
			if (pass) begin
				pend_col_q <= x_q;
				pend_color_q <= texel_q;
				if (pend_q) begin
					out_col_q <= pend_col_q;
					out_row_q <= row_q[5:0];
					out_color_q <= pend_color_q;
					out_last_q <= 1'b0;
				end
			end
		end
		if ((state_q == S_FLUSH) && pend_q && !out_busy) begin
			out_col_q <= pend_col_q;
			out_row_q <= row_q[5:0];
			out_color_q <= pend_color_q;
			out_last_q <= 1'b1;
		end
	end

	assign pix_valid = out_valid_q;
	assign pixel_column = out_col_q;
	assign pixel_row = out_row_q;
	assign pixel_color = out_color_q;
	assign last = out_last_q;

endmodule

// ===== rtl/core/env_mapped_span_fill_zbuffer_core.sv =====
// ----------------------------------------------------------------------------
// env_mapped_span_fill_zbuffer_core: environment-mapped span filler
// Depth-tested span fill with an environment-map texel per pixel.
//
//   channel | direction | handshake              | payload
//   item    | in        | item_valid / item_stall | func .. map_byte
//   pixel   | out       | pix_valid / pix_stall   | pixel_column .. last
//   apb     | in/out    | psel, penable, pready   | paddr, pwdata, prdata
//
// A span is dequeued, runs through the step divider, then walks its pixels,
// each with a depth read, then a test and write, and ends with a flush.
// Load items write the map as they are dequeued; clear items and reset sweep
// the depth store (SCREEN_WIDTH*SCREEN_HEIGHT words, 4096 by default), no spans run then.
// A stalled pixel output holds the walker only when a second pass is due.
// ----------------------------------------------------------------------------
module env_mapped_span_fill_zbuffer_core
	import ems_pkg::*;
#(
	parameter int SCREEN_WIDTH = 64,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         func,
	input  logic signed [15:0] x_start,
	input  logic signed [15:0] x_end,
	input  logic signed [15:0] row,
	input  logic signed [31:0] depth_start,
	input  logic signed [31:0] depth_end,
	input  logic signed [31:0] normal_x_start,
	input  logic signed [31:0] normal_y_start,
	input  logic signed [31:0] normal_x_end,
	input  logic signed [31:0] normal_y_end,
	input  logic [13:0]        map_address,
	input  logic [7:0]         map_byte,
	output logic               pix_valid,
	input  logic               pix_stall,
	output logic [5:0]         pixel_column,
	output logic [5:0]         pixel_row,
	output logic [7:0]         pixel_color,
	output logic               last,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [15:0] slack_q;
	logic        q_full, q_push, q_pop, q_avail;
	span_cmd_t   q_in, q_head;

	// configuration register
	assign pready = 1'b1;
	assign prdata = {16'd0, slack_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			slack_q <= SLACK_RESET;
		else if (psel && penable && pwrite && (paddr == CFG_DEPTH_SLACK))
			slack_q <= pwdata[15:0];
	end

	ems_front #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.item_valid     (item_valid),
		.queue_full     (q_full),
		.item_stall     (item_stall),
		.func           (func),
		.x_start        (x_start),
		.x_end          (x_end),
		.row            (row),
		.depth_start    (depth_start),
		.depth_end      (depth_end),
		.normal_x_start (normal_x_start),
		.normal_y_start (normal_y_start),
		.normal_x_end   (normal_x_end),
		.normal_y_end   (normal_y_end),
		.map_address    (map_address),
		.map_byte       (map_byte),
		.push           (q_push),
		.push_cmd       (q_in)
	);

	ems_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.avail    (q_avail),
		.head     (q_head)
	);

	ems_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_avail    (q_avail),
		.cmd          (q_head),
		.cmd_pop      (q_pop),
		.depth_slack  (slack_q),
		.pix_valid    (pix_valid),
		.pix_stall    (pix_stall),
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row),
		.pixel_color  (pixel_color),
		.last         (last)
	);

endmodule

// ===== rtl/core/ems_checker.sv =====
// ----------------------------------------------------------------------------
// ems_checker: port-level checks of the span filler
// Watches the pixel channel and the register port over time.
// ----------------------------------------------------------------------------
module ems_checker #(
	parameter int SCREEN_WIDTH = 64,
	parameter int SCREEN_HEIGHT = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        pix_valid,
	input logic        pix_stall,
	input logic [5:0]  pixel_column,
	input logic [5:0]  pixel_row,
	input logic [7:0]  pixel_color,
	input logic        last,
	input logic [31:0] prdata
);

	// hold a stalled pixel
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> pix_valid)
		else $error("pixel dropped while stalled");

	a_pix_stable: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> $stable(pixel_column) && $stable(pixel_row)
			&& $stable(pixel_color) && $stable(last))
		else $error("stalled pixel changed");

	// pixels land on screen
	a_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> (32'(pixel_column) < SCREEN_WIDTH) && (32'(pixel_row) < SCREEN_HEIGHT))
		else $error("pixel off screen");

	// register readback stays within the slack width
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[31:16] == 16'd0)
		else $error("readback upper bits set");

endmodule

bind env_mapped_span_fill_zbuffer_core ems_checker #(
	.SCREEN_WIDTH  (SCREEN_WIDTH),
	.SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_ems_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pix_valid    (pix_valid),
	.pix_stall    (pix_stall),
	.pixel_column (pixel_column),
	.pixel_row    (pixel_row),
	.pixel_color  (pixel_color),
	.last         (last),
	.prdata       (prdata)
);

// ===== tb/span_pixel_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// span_pixel_checker: pixel write prediction and comparison
// Watches the item, pixel and register channels of the span filler. It
// tracks the depth store, the environment map and the depth slack, predicts
// the pixel writes of every accepted span, and compares each pixel transfer
// field by field with the oldest predicted write.
// ----------------------------------------------------------------------------
module span_pixel_checker
	import ems_pkg::*;
#(
	parameter int SCREEN_W = 64,
	parameter int SCREEN_H = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_stall,
	input  logic [1:0]         func,
	input  logic signed [15:0] x_start,
	input  logic signed [15:0] x_end,
	input  logic signed [15:0] row,
	input  logic signed [31:0] depth_start,
	input  logic signed [31:0] depth_end,
	input  logic signed [31:0] normal_x_start,
	input  logic signed [31:0] normal_y_start,
	input  logic signed [31:0] normal_x_end,
	input  logic signed [31:0] normal_y_end,
	input  logic [13:0]        map_address,
	input  logic [7:0]         map_byte,
	input  logic               pix_valid,
	input  logic               pix_stall,
	input  logic [5:0]         pixel_column,
	input  logic [5:0]         pixel_row,
	input  logic [7:0]         pixel_color,
	input  logic               last,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 errors,
	output int                 outstanding,
	output int                 pixels_seen,
	output int                 spans_seen
);

	localparam logic [1:0] REG_DEPTH_SLACK = 2'd0;
	localparam int MAP_BYTES = 16384;

	typedef struct packed {
		logic [5:0] column;
		logic [5:0] prow;
		logic [7:0] color;
		logic       is_last;
	} pixel_write_t;

	logic [31:0]  depth_mem [SCREEN_W*SCREEN_H];
	logic [7:0]   env_map [MAP_BYTES];
	logic [15:0]  slack;
	pixel_write_t expected_pixels [$];

	assign outstanding = expected_pixels.size();

	// walk one span and queue the pixels that pass the depth test
	task automatic fill_span();
		longint x1, x2, r, len, dz, dx, dy, nx, ny, nz, d, stored, ry, rx, addr;
		int idx;
		int first;
		pixel_write_t p;
		x1 = x_start;
		x2 = x_end;
		r = row;
		first = expected_pixels.size();
		if (r >= SCREEN_H || r < 0 || x2 < 0 || x1 >= SCREEN_W) return;
		if (x1 < 0) x1 = 0;
		if (x2 >= SCREEN_W) x2 = SCREEN_W - 1;
		len = x2 - x1;
		if (len <= 0) return;
		nz = depth_start;
		nx = normal_x_start;
		ny = normal_y_start;
		dz = (longint'(depth_end) - nz) / len;
		dx = (longint'(normal_x_end) - nx) / len;
		dy = (longint'(normal_y_end) - ny) / len;
		for (longint x = x1; x <= x2; x++) begin
			ry = ((ny < 0 ? -ny : ny) >> 7) + 64;
			rx = ((nx < 0 ? -nx : nx) >> 7) + 64;
			addr = ((ry << 7) + rx) & (MAP_BYTES - 1);
			idx = int'(r * SCREEN_W + x);
			d = nz >>> 8;
			stored = longint'($signed(depth_mem[idx]));
			if (d - stored < longint'(slack)) begin
				depth_mem[idx] = d[31:0];
				p.column = x[5:0];
				p.prow = r[5:0];
				p.color = env_map[addr];
				p.is_last = 1'b0;
				expected_pixels.push_back(p);
			end
			nx += dx;
			ny += dy;
			nz += dz;
		end
		if (expected_pixels.size() > first)
			expected_pixels[expected_pixels.size()-1].is_last = 1'b1;
	endtask

	// track state and compare pixel transfers
	always @(posedge clk or negedge arst_n) begin
		pixel_write_t want;
		if (!arst_n) begin
			foreach (depth_mem[i]) depth_mem[i] = DEPTH_FILL;
			slack = SLACK_RESET;
			expected_pixels.delete();
			errors = 0;
			pixels_seen = 0;
			spans_seen = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == REG_DEPTH_SLACK)
				slack = pwdata[15:0];
			if (pix_valid && !pix_stall) begin
				pixels_seen++;
				if (expected_pixels.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected pixel col %0d row %0d color %0h last %0b",
							$realtime, pixel_column, pixel_row, pixel_color, last);
				end else begin
					want = expected_pixels.pop_front();
					if (want.column !== pixel_column || want.prow !== pixel_row ||
							want.color !== pixel_color || want.is_last !== last) begin
						errors++;
						if (errors <= 10)
							$display("%0t: pixel mismatch exp col %0d row %0d color %0h last %0b, got col %0d row %0d color %0h last %0b",
								$realtime, want.column, want.prow, want.color, want.is_last,
								pixel_column, pixel_row, pixel_color, last);
					end
				end
			end
			if (item_valid && !item_stall) begin
				case (func)
					FUNC_DRAW: begin
						spans_seen++;
						fill_span();
					end
					FUNC_CLEAR: foreach (depth_mem[i]) depth_mem[i] = DEPTH_FILL;
					FUNC_LOAD: env_map[map_address] = map_byte;
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: span filler testbench
// Loads the map texels that the stimulus normals can reach, then drives
// directed and random spans, clears and loads under random idling on both
// channels, across several depth slack settings. A checker beside the block
// predicts every pixel.
// ----------------------------------------------------------------------------
module tb_top;
	import ems_pkg::*;

	localparam logic [1:0] REG_DEPTH_SLACK = 2'd0;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	// back end plus two queued commands, each up to a full depth sweep
	localparam int SETTLE_CYCLES = 13000;
	localparam int NORMAL_MAX = 511;

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	logic [1:0]         func;
	logic signed [15:0] x_start, x_end, row;
	logic signed [31:0] depth_start, depth_end;
	logic signed [31:0] normal_x_start, normal_y_start, normal_x_end, normal_y_end;
	logic [13:0]        map_address;
	logic [7:0]         map_byte;
	logic               pix_valid, pix_stall;
	logic [5:0]         pixel_column, pixel_row;
	logic [7:0]         pixel_color;
	logic               last;
	logic               psel, penable, pwrite, pready;
	logic [1:0]         paddr;
	logic [31:0]        pwdata, prdata;
	logic               calm;
	int                 errors, outstanding, pixels_seen, spans_seen;

	env_mapped_span_fill_zbuffer_core dut (.*);

	span_pixel_checker checker_i (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#3000000;
		$display("env_mapped_span_fill_zbuffer_core test failed");
		$finish;
	end

	// random pixel stall
	always @(negedge clk)
		pix_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 33);

	// normal component that keeps texel reads inside the loaded corner
	function automatic logic signed [31:0] rand_normal();
		int v;
		v = int'($urandom_range(0, 2 * NORMAL_MAX)) - NORMAL_MAX;
		return v;
	endfunction

	// one transfer on the item channel, entered and left at a falling edge
	task automatic send_item(input logic [1:0] f, input logic signed [15:0] xs, xe, rw,
			input logic signed [31:0] ds, de, nxs, nys, nxe, nye,
			input logic [13:0] ma, input logic [7:0] mb);
		while (!calm && $urandom_range(0, 99) < 33) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		func = f;
		x_start = xs;
		x_end = xe;
		row = rw;
		depth_start = ds;
		depth_end = de;
		normal_x_start = nxs;
		normal_y_start = nys;
		normal_x_end = nxe;
		normal_y_end = nye;
		map_address = ma;
		map_byte = mb;
		item_valid = 1'b1;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
	endtask

	task automatic span(input logic signed [15:0] xs, xe, rw,
			input logic signed [31:0] ds, de, nxs, nys, nxe, nye);
		send_item(FUNC_DRAW, xs, xe, rw, ds, de, nxs, nys, nxe, nye,
			14'($urandom), 8'($urandom));
	endtask

	task automatic clear_depth();
		send_item(FUNC_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom, 14'($urandom), 8'($urandom));
	endtask

	// hold off until every pixel is out and any sweep is done, then write
	task automatic set_slack(input logic [15:0] value);
		item_valid = 1'b0;
		wait (outstanding == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = REG_DEPTH_SLACK;
		pwdata = {16'($urandom), value};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// mostly well-formed spans with random content, some commands and noise
	task automatic random_item();
		int k;
		int signed base;
		logic signed [15:0] xs, rw;
		k = $urandom_range(0, 99);
		base = $urandom_range(0, 1 << 21) - (1 << 20);
		xs = 16'($urandom_range(0, 84)) - 16'sd12;
		rw = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 63));
		if (k < 5)
			clear_depth();
		else if (k < 9)
			send_item(FUNC_LOAD, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom, 14'($urandom),
				8'($urandom));
		else if (k < 16)
			span(16'($urandom), 16'($urandom), rw, $urandom, $urandom, rand_normal(),
				rand_normal(), rand_normal(), rand_normal());
		else if (k < 24)
			span(xs, 16'(xs + $urandom_range(0, 80) - 4), rw, $urandom, $urandom,
				rand_normal(), rand_normal(), rand_normal(), rand_normal());
		else
			span(xs, 16'(xs + $urandom_range(0, 80) - 4), rw, base,
				base + $urandom_range(0, 1 << 19) - (1 << 18), rand_normal(),
				rand_normal(), rand_normal(), rand_normal());
	endtask

	initial begin
		calm = 1'b0;
		item_valid = 1'b0;
		func = FUNC_DRAW;
		{x_start, x_end, row} = '0;
		{depth_start, depth_end} = '0;
		{normal_x_start, normal_y_start, normal_x_end, normal_y_end} = '0;
		map_address = '0;
		map_byte = '0;
		{psel, penable, pwrite} = '0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_slack(16'hFFFF);

		// load every texel that normals within +/-NORMAL_MAX can reach
		for (int r = 64; r < 68; r++)
			for (int c = 64; c < 68; c++)
				send_item(FUNC_LOAD, 16'($urandom), 16'($urandom), 16'($urandom),
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					14'(r * 128 + c), 8'($urandom));

		// directed: extremes, clipping and every rejection case
		span(0, 63, 63, 32'sh7FFF_FFFF, 32'sh8000_0000, -NORMAL_MAX,
			NORMAL_MAX, NORMAL_MAX, -NORMAL_MAX);
		span(-16'sd32768, 16'sd32767, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0,
			32'shFFFF_FFFF, 32'shFFFF_FFFF);
		span(-5, 10, 5, 100000, -100000, 100, -100, 500, -500);
		span(50, 80, 6, 0, 65536, 0, 0, 0, 0);
		span(0, 5, -1, 0, 0, 0, 0, 0, 0);
		span(0, 5, 64, 0, 0, 0, 0, 0, 0);
		span(0, 5, -16'sd32768, 0, 0, 0, 0, 0, 0);
		span(-10, -1, 7, 0, 0, 0, 0, 0, 0);
		span(64, 70, 7, 0, 0, 0, 0, 0, 0);
		span(16'sd32767, 16'sd32767, 7, 0, 0, 0, 0, 0, 0);
		span(9, 9, 8, 0, 0, 0, 0, 0, 0);
		span(20, 10, 8, 0, 0, 0, 0, 0, 0);
		span(-3, 0, 8, 0, 0, 0, 0, 0, 0);
		span(63, 100, 8, 0, 0, 0, 0, 0, 0);
		span(0, 1, 9, 256, 512, 127, -128, 128, -129);
		send_item(FUNC_UNUSED, 0, 63, 10, 0, 0, 0, 0, 0, 0, 14'h3FFF, 8'hFF);
		send_item(FUNC_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 14'h2040, 8'hA5);
		span(0, 63, 10, 0, 0, 0, 0, 0, 0);
		span(0, 63, 10, 32'h0100_0000, 32'h0100_0000, 0, 0, 0, 0);
		clear_depth();
		span(0, 63, 10, 0, 0, 0, 0, 0, 0);

		// random phases over several slack settings
		set_slack(16'h0000);
		for (int i = 0; i < 40; i++) random_item();
		set_slack(16'($urandom));
		calm = 1'b1;
		for (int i = 0; i < 30; i++) random_item();
		calm = 1'b0;
		for (int i = 0; i < 20; i++) random_item();
		set_slack(SLACK_RESET);
		for (int i = 0; i < 40; i++) random_item();
		set_slack(16'($urandom_range(0, 64)));
		for (int i = 0; i < 40; i++) random_item();

		item_valid = 1'b0;
		wait (outstanding == 0);
		repeat (300) @(posedge clk);
		$display("Covered %0d span items and %0d pixel transfers over five slack settings",
			spans_seen, pixels_seen);
		if (errors == 0 && outstanding == 0)
			$display("env_mapped_span_fill_zbuffer_core test passed");
		else
			$display("env_mapped_span_fill_zbuffer_core test failed");
		$finish;
	end

endmodule
